// ----- rtl/dpdc_pkg.sv -----
// Shared types and constants of the dual PD drive controller.
package dpdc_pkg;

    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 15;
    localparam int HEAD_W      = 17;
    localparam int TICKS_W     = 12;
    localparam int OUT_W       = 16;
    localparam int FRAC_BITS   = 8;
    localparam int HDG_DER_W   = HEAD_W + 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_MAX     = 32767;
    localparam int OUT_MIN     = -32768;

    localparam logic [CFG_ADDR_W-1:0] REG_LIN_P_GAIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIN_D_GAIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANG_P_GAIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANG_D_GAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DRIVE  = 3'd4;

    localparam logic [GAIN_W-1:0]  LIN_P_GAIN_RST = 16'd25600;
    localparam logic [GAIN_W-1:0]  ANG_P_GAIN_RST = 16'd25600;
    localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST  = 15'd10000;

    // Divider status as seen by the sequencer.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DRIVE_W-1:0] quotient;
    } div_stat_t;

endpackage

// ----- rtl/dpdc_div.sv -----
// Iterative restoring divider for the slew step, one quotient bit per cycle.
module dpdc_div import dpdc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DRIVE_W-1:0] dividend,
    input  logic [TICKS_W-1:0] divisor,
    output div_stat_t          stat
);

    localparam int CNT_W = $clog2(DRIVE_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DRIVE_W-1:0] quo_reg;
    logic [TICKS_W-1:0] rem_reg;
    logic [TICKS_W-1:0] dvs_reg;
    logic [TICKS_W:0]   shifted;
    logic [TICKS_W:0]   trial;
    logic               fits;

    // Bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DRIVE_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DRIVE_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DRIVE_W-2:0], fits};
            rem_reg <= fits ? trial[TICKS_W-1:0] : shifted[TICKS_W-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ----- rtl/dual_pd_drive_controller.sv -----
// Top level of the dual PD drive controller with slew-limited linear drive.
//
// A start transfer (s_op = 1) loads the distance and heading targets and the slew
// settings and returns nothing. A tick transfer (s_op = 0) runs the distance and
// heading PD loops and returns one result: left = linear + angular and right =
// linear - angular, each saturated to 16 bits, plus a flag telling whether the
// linear drive came from the slew ramp. All four products go through one shared
// signed multiplier, one at a time. The sequencer spends one step on the errors,
// one on the error changes, two multiplies, a sum and an output step per loop and
// one final step; the next item can be taken once it is back in idle. While the
// slew ramp is active with a nonzero tick count the step is found by a bit-serial
// divider that produces 15 quotient bits before the final step. s_ready is high
// only while the sequencer is idle; a finished result waits in the output
// register, and the next item may be taken meanwhile. If that register is still
// full when the next tick finishes, the sequencer holds in its final step until it
// drains. Gains and max_drive are written through the cfg port; the user must
// write them only while the block is idle, which the block does not enforce. A
// write to an index beyond the register list is ignored.
module dual_pd_drive_controller import dpdc_pkg::*; #(
    parameter int POSITION_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [POSITION_BITS-1:0] s_measured_position,
    input  logic [HEAD_W-1:0]            s_measured_heading,
    input  logic signed [POSITION_BITS-1:0] s_goal_distance,
    input  logic [HEAD_W-1:0]            s_goal_heading,
    input  logic                         s_slew_on,
    input  logic [DRIVE_W-1:0]           s_slew_initial,
    input  logic [TICKS_W-1:0]           s_slew_ticks,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_W-1:0]      m_left_drive,
    output logic signed [OUT_W-1:0]      m_right_drive,
    output logic                         m_slewing
);

    // Operand width: covers the distance derivative and the heading derivative.
    localparam int AW  = (POSITION_BITS + 2 > HDG_DER_W) ? POSITION_BITS + 2 : HDG_DER_W;
    localparam int PW  = AW + GAIN_W + 1;        // one product
    localparam int ACW = PW + 1;                 // sum of two products
    localparam int LW  = ACW - FRAC_BITS;        // loop output after the shift
    localparam int SW  = LW + 1;                 // linear +/- angular
    localparam int PE  = POSITION_BITS + 1;      // stored distance error

    localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

    // Sequencer codes.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIFF   = 4'd1;
    localparam logic [3:0] ST_LMUL_P = 4'd2;
    localparam logic [3:0] ST_LMUL_D = 4'd3;
    localparam logic [3:0] ST_LSUM   = 4'd4;
    localparam logic [3:0] ST_LOUT   = 4'd5;
    localparam logic [3:0] ST_AMUL_P = 4'd6;
    localparam logic [3:0] ST_AMUL_D = 4'd7;
    localparam logic [3:0] ST_ASUM   = 4'd8;
    localparam logic [3:0] ST_AOUT   = 4'd9;
    localparam logic [3:0] ST_DIV    = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    // Configuration registers.
    logic [GAIN_W-1:0]  lin_p_gain_reg;
    logic [GAIN_W-1:0]  lin_d_gain_reg;
    logic [GAIN_W-1:0]  ang_p_gain_reg;
    logic [GAIN_W-1:0]  ang_d_gain_reg;
    logic [DRIVE_W-1:0] max_drive_reg;

    // Move state.
    logic signed [POSITION_BITS-1:0] target_dist_reg;
    logic [HEAD_W-1:0]               target_hdg_reg;
    logic signed [PE-1:0]            last_lin_err_reg;
    logic signed [HEAD_W:0]          last_ang_err_reg;
    logic                            slew_en_reg;
    logic [DRIVE_W-1:0]              slew_level_reg;
    logic [TICKS_W-1:0]              slew_div_reg;

    // Working registers of one tick.
    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic signed [AW-1:0]    lin_err_reg;
    logic signed [AW-1:0]    ang_err_reg;
    logic signed [AW-1:0]    lin_der_reg;
    logic signed [AW-1:0]    ang_der_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACW-1:0]   acc_reg;
    logic signed [LW-1:0]    lin_reg;
    logic signed [LW-1:0]    ang_reg;
    logic                    slewing_reg;

    // Output register.
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_left_reg;
    logic signed [OUT_W-1:0] m_right_reg;
    logic                    m_slewing_reg;

    // Shared multiplier and datapath helpers.
    logic signed [AW-1:0]     mul_a;
    logic [GAIN_W-1:0]        mul_gain;
    logic signed [GAIN_W:0]   mul_b;
    logic signed [PW-1:0]     mul_prod;
    logic signed [LW-1:0]     pd_out;
    logic signed [LW-1:0]     max_ext;
    logic signed [LW-1:0]     lvl_ext;
    logic signed [SW-1:0]     sum_lr;
    logic signed [SW-1:0]     dif_lr;
    logic signed [OUT_W-1:0]  left_sat;
    logic signed [OUT_W-1:0]  right_sat;
    logic                     in_xfer;
    logic                     out_free;
    logic                     slew_active;
    logic                     div_start;
    logic [DRIVE_W-1:0]       slew_step;
    div_stat_t                div_stat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Configuration writes; unknown indexes fall through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_p_gain_reg <= LIN_P_GAIN_RST;
            lin_d_gain_reg <= '0;
            ang_p_gain_reg <= ANG_P_GAIN_RST;
            ang_d_gain_reg <= '0;
            max_drive_reg  <= MAX_DRIVE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LIN_P_GAIN: lin_p_gain_reg <= cfg_wdata;
                REG_LIN_D_GAIN: lin_d_gain_reg <= cfg_wdata;
                REG_ANG_P_GAIN: ang_p_gain_reg <= cfg_wdata;
                REG_ANG_D_GAIN: ang_d_gain_reg <= cfg_wdata;
                REG_MAX_DRIVE:  max_drive_reg  <= cfg_wdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pick the operands of the shared multiplier for the current step.
    always_comb begin
        unique case (state_reg)
            ST_LMUL_P: begin
                mul_a    = lin_err_reg;
                mul_gain = lin_p_gain_reg;
            end
            ST_LMUL_D: begin
                mul_a    = lin_der_reg;
                mul_gain = lin_d_gain_reg;
            end
            ST_AMUL_P: begin
                mul_a    = ang_err_reg;
                mul_gain = ang_p_gain_reg;
            end
            default: begin
                mul_a    = ang_der_reg;
                mul_gain = ang_d_gain_reg;
            end
        endcase
    end

    assign mul_b    = $signed({1'b0, mul_gain});
    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    // Arithmetic shift of the Q36.8 sum (for POSITION_BITS = 24) rounds toward minus infinity.
    assign pd_out  = LW'(acc_reg >>> FRAC_BITS);
    assign max_ext = $signed({{(LW - DRIVE_W){1'b0}}, max_drive_reg});
    assign lvl_ext = $signed({{(LW - DRIVE_W){1'b0}}, slew_level_reg});
    assign slew_active = slew_en_reg && (slew_level_reg < max_drive_reg);

    // Slew step is at least one millivolt.
    assign slew_step = (div_stat.quotient == '0) ? DRIVE_W'(1) : div_stat.quotient;
    assign div_start = (state_reg == ST_AOUT) && slewing_reg && (slew_div_reg != '0);

    // Final mix and saturation to the output width.
    assign sum_lr = SW'(lin_reg) + SW'(ang_reg);
    assign dif_lr = SW'(lin_reg) - SW'(ang_reg);

    always_comb begin
        priority if (sum_lr > SAT_HI) left_sat = OUT_W'(SAT_HI);
        else if (sum_lr < SAT_LO)     left_sat = OUT_W'(SAT_LO);
        else                          left_sat = OUT_W'(sum_lr);
        priority if (dif_lr > SAT_HI) right_sat = OUT_W'(SAT_HI);
        else if (dif_lr < SAT_LO)     right_sat = OUT_W'(SAT_LO);
        else                          right_sat = OUT_W'(dif_lr);
    end

    // Sequencer: one multiply, add or compare per step.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_xfer && !s_op) state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_LMUL_P;
            ST_LMUL_P: state_next = ST_LMUL_D;
            ST_LMUL_D: state_next = ST_LSUM;
            ST_LSUM:   state_next = ST_LOUT;
            ST_LOUT:   state_next = ST_AMUL_P;
            ST_AMUL_P: state_next = ST_AMUL_D;
            ST_AMUL_D: state_next = ST_ASUM;
            ST_ASUM:   state_next = ST_AOUT;
            ST_AOUT:   state_next = div_start ? ST_DIV : ST_DONE;
            ST_DIV:    if (div_stat.done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state and move state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            target_dist_reg  <= '0;
            target_hdg_reg   <= '0;
            last_lin_err_reg <= '0;
            last_ang_err_reg <= '0;
            slew_en_reg      <= 1'b0;
            slew_level_reg   <= '0;
            slew_div_reg     <= '0;
            slewing_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Load a new move; the last errors carry over.
            if (in_xfer && s_op) begin
                target_dist_reg <= s_goal_distance;
                target_hdg_reg  <= s_goal_heading;
                slew_en_reg     <= s_slew_on;
                slew_level_reg  <= s_slew_initial;
                slew_div_reg    <= s_slew_ticks;
            end

            if (state_reg == ST_LOUT) begin
                slewing_reg      <= slew_active;
                last_lin_err_reg <= PE'(lin_err_reg);
            end

            if (state_reg == ST_AOUT) begin
                last_ang_err_reg <= (HEAD_W + 1)'(ang_err_reg);
                // A zero tick count jumps straight to the ceiling.
                if (slewing_reg && (slew_div_reg == '0)) begin
                    slew_level_reg <= max_drive_reg;
                end
            end

            // Advance the ramp by the divided step.
            if ((state_reg == ST_DIV) && div_stat.done) begin
                slew_level_reg <= slew_level_reg + slew_step;
            end

            // Hand the result to the output register; drop valid once taken.
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                lin_err_reg <= AW'(target_dist_reg) - AW'(s_measured_position);
                ang_err_reg <= $signed(AW'({1'b0, target_hdg_reg}))
                             - $signed(AW'({1'b0, s_measured_heading}));
            end
            ST_DIFF: begin
                lin_der_reg <= lin_err_reg - AW'(last_lin_err_reg);
                ang_der_reg <= ang_err_reg - AW'(last_ang_err_reg);
            end
            ST_LMUL_P, ST_AMUL_P: begin
                prod_reg <= mul_prod;
            end
            ST_LMUL_D, ST_AMUL_D: begin
                acc_reg  <= ACW'(prod_reg);
                prod_reg <= mul_prod;
            end
            ST_LSUM, ST_ASUM: begin
                acc_reg <= acc_reg + ACW'(prod_reg);
            end
            ST_LOUT: begin
                // Ramp replaces the PD magnitude but keeps its sign.
                if (slew_active) begin
                    if (pd_out > 0)      lin_reg <= lvl_ext;
                    else if (pd_out < 0) lin_reg <= -lvl_ext;
                    else                 lin_reg <= '0;
                end else begin
                    lin_reg <= (pd_out > max_ext) ? max_ext : pd_out;
                end
            end
            ST_AOUT: begin
                ang_reg <= (pd_out > max_ext) ? max_ext : pd_out;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_left_reg    <= left_sat;
                    m_right_reg   <= right_sat;
                    m_slewing_reg <= slewing_reg;
                end
            end
            default: ;
        endcase
    end

    dpdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (max_drive_reg - slew_level_reg),
        .divisor  (slew_div_reg),
        .stat     (div_stat)
    );

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = m_left_reg;
    assign m_right_drive = m_right_reg;
    assign m_slewing     = m_slewing_reg;

    // The divider only runs for a tick that took its drive from the ramp.
    a_div_only_slewing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> slewing_reg)
        else $error("divider in use without slew ramp");

    // A divider result only arrives while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide step");

    // An accepted tick starts the computation on the next cycle.
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_op) |=> (state_reg == ST_DIFF))
        else $error("tick transfer did not start the loop");

    // Finishing a tick presents a result and returns to idle.
    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished tick did not present a result");

endmodule

// ----- bench/dual_pd_drive_controller_tb.sv -----
// Self-checking bench for the dual PD drive controller: directed table, then random moves.
`timescale 1ns / 1ps

module dual_pd_drive_controller_tb;
    import dpdc_pkg::*;

    localparam int     POSITION_BITS     = 24;
    localparam longint POS_MAX           = (longint'(1) << (POSITION_BITS - 1)) - 1;
    localparam longint POS_MIN           = -(longint'(1) << (POSITION_BITS - 1));
    localparam longint HEADING_MAX       = 92159;
    localparam longint HEADING_FIELD_MAX = (longint'(1) << HEAD_W) - 1;
    localparam int     GAIN_PHASES       = 10;
    localparam int     ITEMS_PER_PHASE   = 170;
    // Idle time after the last owed result, long enough for a slewing tick, before touching registers.
    localparam int     SETTLE_CYCLES     = 64;
    localparam int     LIMIT_CYCLES      = 1000000;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [POSITION_BITS-1:0] meas_pos;
        logic [HEAD_W-1:0]        meas_hdg;
        logic [POSITION_BITS-1:0] goal_dist;
        logic [HEAD_W-1:0]        goal_hdg;
        logic                     slew_on;
        logic [DRIVE_W-1:0]       slew_init;
        logic [TICKS_W-1:0]       slew_ticks;
    } drive_cmd_t;

    localparam int CMD_BITS = $bits(drive_cmd_t);

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] right;
        logic             slewing;
    } drive_out_t;

    typedef struct packed {
        drive_cmd_t cmd;
        logic       typed;
        drive_out_t want;
    } table_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [CFG_ADDR_W-1:0]           cfg_addr;
    logic [CFG_DATA_W-1:0]           cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_op;
    logic signed [POSITION_BITS-1:0] s_measured_position;
    logic [HEAD_W-1:0]               s_measured_heading;
    logic signed [POSITION_BITS-1:0] s_goal_distance;
    logic [HEAD_W-1:0]               s_goal_heading;
    logic                            s_slew_on;
    logic [DRIVE_W-1:0]              s_slew_initial;
    logic [TICKS_W-1:0]              s_slew_ticks;
    logic                            m_valid;
    logic                            m_ready;
    logic signed [OUT_W-1:0]         m_left_drive;
    logic signed [OUT_W-1:0]         m_right_drive;
    logic                            m_slewing;

    // Mirror of the gain registers and of the controller state.
    longint lin_kp, lin_kd, ang_kp, ang_kd, drive_cap;
    longint goal_dist_q, goal_hdg_q, prev_lin_err, prev_ang_err;
    bit     ramp_on;
    longint ramp_level, ramp_div;

    // Drive results still owed by the block, oldest first.
    drive_out_t expected_drive[$];

    int fail_count;
    int results_seen;
    int slew_results;
    int starts_sent;
    int ticks_sent;
    int cycle_count;
    int burst_left;

    dual_pd_drive_controller #(
        .POSITION_BITS(POSITION_BITS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_measured_position(s_measured_position),
        .s_measured_heading (s_measured_heading),
        .s_goal_distance    (s_goal_distance),
        .s_goal_heading     (s_goal_heading),
        .s_slew_on          (s_slew_on),
        .s_slew_initial     (s_slew_initial),
        .s_slew_ticks       (s_slew_ticks),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_left_drive       (m_left_drive),
        .m_right_drive      (m_right_drive),
        .m_slewing          (m_slewing)
    );

    // 4 ns clock.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // One PD loop: error times P plus change of error times D, floored by 8 fraction bits.
    function automatic longint pd_loop(input longint err, input longint last,
                                       input longint kp, input longint kd);
        return (err * kp + (err - last) * kd) >>> FRAC_BITS;
    endfunction

    function automatic logic [OUT_W-1:0] sat_drive(input longint v);
        if (v > OUT_MAX)
            return OUT_W'(OUT_MAX);
        if (v < OUT_MIN)
            return OUT_W'(OUT_MIN);
        return OUT_W'(v);
    endfunction

    // Advance the mirrored controller by one transfer; return 1 when a result is due.
    function automatic bit predict_drive(input drive_cmd_t c, output drive_out_t r);
        longint lin_err, ang_err, lin, ang, stepv;
        r = '0;
        if (c.op == OP_START) begin
            goal_dist_q = $signed(c.goal_dist);
            goal_hdg_q  = longint'(c.goal_hdg);
            ramp_on     = c.slew_on;
            ramp_level  = longint'(c.slew_init);
            ramp_div    = longint'(c.slew_ticks);
            return 1'b0;
        end

        lin_err = goal_dist_q - $signed(c.meas_pos);
        lin = pd_loop(lin_err, prev_lin_err, lin_kp, lin_kd);
        if (ramp_on && ramp_level < drive_cap) begin
            // Ramp owns the linear drive: keep only the sign of the PD output.
            lin = (lin > 0) ? ramp_level : ((lin < 0) ? -ramp_level : 0);
            r.slewing = 1'b1;
            if (ramp_div == 0) begin
                ramp_level = drive_cap;
            end else begin
                stepv = (drive_cap - ramp_level) / ramp_div;
                if (stepv < 1)
                    stepv = 1;
                ramp_level = ramp_level + stepv;
                if (ramp_level > drive_cap)
                    ramp_level = drive_cap;
            end
        end else if (lin > drive_cap) begin
            lin = drive_cap;
        end
        prev_lin_err = lin_err;

        // Heading error is a plain difference, no wrap at a full turn.
        ang_err = goal_hdg_q - longint'(c.meas_hdg);
        ang = pd_loop(ang_err, prev_ang_err, ang_kp, ang_kd);
        if (ang > drive_cap)
            ang = drive_cap;
        prev_ang_err = ang_err;

        r.left  = sat_drive(lin + ang);
        r.right = sat_drive(lin - ang);
        return 1'b1;
    endfunction

    function automatic table_row_t tick_row(input longint pos, input longint hdg,
                                            input logic typed, input longint left,
                                            input longint right, input logic slewing);
        table_row_t r;
        r               = '0;
        r.cmd.op        = OP_TICK;
        r.cmd.meas_pos  = POSITION_BITS'(pos);
        r.cmd.meas_hdg  = HEAD_W'(hdg);
        r.typed         = typed;
        r.want.left     = OUT_W'(left);
        r.want.right    = OUT_W'(right);
        r.want.slewing  = slewing;
        return r;
    endfunction

    function automatic table_row_t start_row(input longint goal, input longint ghdg,
                                             input logic slew, input longint init,
                                             input longint ticks);
        table_row_t r;
        r                = '0;
        r.cmd.op         = OP_START;
        r.cmd.goal_dist  = POSITION_BITS'(goal);
        r.cmd.goal_hdg   = HEAD_W'(ghdg);
        r.cmd.slew_on    = slew;
        r.cmd.slew_init  = DRIVE_W'(init);
        r.cmd.slew_ticks = TICKS_W'(ticks);
        return r;
    endfunction

    // Mostly near the aim point, sometimes anywhere in the field.
    function automatic logic [POSITION_BITS-1:0] pick_position(input longint aim);
        case ($urandom_range(0, 9))
            0, 1:    return POSITION_BITS'($urandom);
            2:       return POSITION_BITS'(aim);
            3, 4, 5: return POSITION_BITS'(aim + longint'($urandom_range(0, 1024)) - 512);
            default: return POSITION_BITS'(aim + longint'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [HEAD_W-1:0] pick_heading(input longint aim);
        case ($urandom_range(0, 9))
            0:       return HEAD_W'($urandom);
            1, 2:    return HEAD_W'($urandom_range(0, HEADING_MAX));
            3:       return HEAD_W'(aim);
            default: return HEAD_W'(aim + longint'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    // Present one transfer, hold it until accepted, then book its result and
    // open a random gap when the current burst runs out.
    task automatic issue(input drive_cmd_t c, input logic typed, input drive_out_t want);
        drive_out_t predicted;
        int         gap;
        s_valid             <= 1'b1;
        s_op                <= c.op;
        s_measured_position <= c.meas_pos;
        s_measured_heading  <= c.meas_hdg;
        s_goal_distance     <= c.goal_dist;
        s_goal_heading      <= c.goal_hdg;
        s_slew_on           <= c.slew_on;
        s_slew_initial      <= c.slew_init;
        s_slew_ticks        <= c.slew_ticks;
        do begin
            @(posedge aclk);
        end while (!s_ready);

        if (predict_drive(c, predicted)) begin
            expected_drive.push_back(typed ? want : predicted);
            ticks_sent++;
        end else begin
            starts_sent++;
        end

        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Wait for every owed result, then let any start still in flight finish.
    task automatic wait_drained();
        while (expected_drive.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all registers for one phase, then poke an unmapped index last so
    // any aliasing would show up in the following results.
    task automatic load_gains(input int phase);
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        for (int w = 0; w <= REG_MAX_DRIVE + 1; w++) begin
            if (w > REG_MAX_DRIVE) begin
                addr = CFG_ADDR_W'($urandom_range(REG_MAX_DRIVE + 1, (1 << CFG_ADDR_W) - 1));
                data = CFG_DATA_W'($urandom);
            end else begin
                addr = CFG_ADDR_W'(w);
                if (phase == 0) begin
                    data = '0;
                end else if (phase == 1) begin
                    data = '1;
                end else if (addr == REG_MAX_DRIVE) begin
                    case ($urandom_range(0, 2))
                        0:       data = CFG_DATA_W'($urandom_range(0, 100));
                        1:       data = CFG_DATA_W'($urandom);
                        default: data = CFG_DATA_W'($urandom_range(1000, 20000));
                    endcase
                end else begin
                    case ($urandom_range(0, 3))
                        0:       data = CFG_DATA_W'($urandom_range(0, 511));
                        1:       data = CFG_DATA_W'($urandom_range(128, 384));
                        2:       data = CFG_DATA_W'($urandom_range(0, 4095));
                        default: data = CFG_DATA_W'($urandom);
                    endcase
                end
            end
            cfg_we    <= 1'b1;
            cfg_addr  <= addr;
            cfg_wdata <= data;
            @(posedge aclk);
            case (addr)
                REG_LIN_P_GAIN: lin_kp    = longint'(data);
                REG_LIN_D_GAIN: lin_kd    = longint'(data);
                REG_ANG_P_GAIN: ang_kp    = longint'(data);
                REG_ANG_D_GAIN: ang_kd    = longint'(data);
                REG_MAX_DRIVE:  drive_cap = longint'(data[DRIVE_W-1:0]);
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Main sequence: reset, directed table, then phases of random moves.
    initial begin
        drive_cmd_t c;
        drive_out_t none;
        table_row_t rows[$];
        longint     seq_goal, hdg_from, hdg_goal, off;
        int         n_ticks;
        int         phase_end;

        // Hold every input at a known value from time zero.
        aresetn             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_addr            <= '0;
        cfg_wdata           <= '0;
        s_valid             <= 1'b0;
        s_op                <= OP_TICK;
        s_measured_position <= '0;
        s_measured_heading  <= '0;
        s_goal_distance     <= '0;
        s_goal_heading      <= '0;
        s_slew_on           <= 1'b0;
        s_slew_initial      <= '0;
        s_slew_ticks        <= '0;

        // Predictor starts from the reset state of the block.
        lin_kp       = longint'(LIN_P_GAIN_RST);
        lin_kd       = 0;
        ang_kp       = longint'(ANG_P_GAIN_RST);
        ang_kd       = 0;
        drive_cap    = longint'(MAX_DRIVE_RST);
        goal_dist_q  = 0;
        goal_hdg_q   = 0;
        prev_lin_err = 0;
        prev_ang_err = 0;
        ramp_on      = 1'b0;
        ramp_level   = 0;
        ramp_div     = 0;
        none         = '0;
        burst_left   = $urandom_range(1, 12);

        // Directed table, run with the reset gains (P = 100.0, D = 0, cap 10000).
        // Quiet controller right after reset.
        rows.push_back(tick_row(0, 0, 1'b1, 0, 0, 1'b0));
        // Huge positive error: clamped at the drive cap.
        rows.push_back(tick_row(POS_MIN, 0, 1'b1, MAX_DRIVE_RST, MAX_DRIVE_RST, 1'b0));
        // Huge negative error: no lower clamp, only the 16 bit saturation.
        rows.push_back(tick_row(POS_MAX, 0, 1'b1, OUT_MIN, OUT_MIN, 1'b0));
        // Heading far behind target, in range and beyond a full turn.
        rows.push_back(tick_row(0, HEADING_MAX, 1'b1, OUT_MIN, OUT_MAX, 1'b0));
        rows.push_back(tick_row(0, HEADING_FIELD_MAX, 1'b1, OUT_MIN, OUT_MAX, 1'b0));
        rows.push_back(tick_row(300, 0, 1'b0, 0, 0, 1'b0));
        // Ramp from zero with no tick count: jumps straight to the cap.
        rows.push_back(start_row(POS_MAX, HEADING_FIELD_MAX, 1'b1, 0, 0));
        rows.push_back(tick_row(POS_MIN, 0, 1'b0, 0, 0, 1'b0));
        rows.push_back(tick_row(0, HEADING_FIELD_MAX, 1'b0, 0, 0, 1'b0));
        // Slow ramp with the longest tick count: the step comes to two.
        rows.push_back(start_row(POS_MIN, 0, 1'b1, 100, (1 << TICKS_W) - 1));
        rows.push_back(tick_row(0, 5000, 1'b0, 0, 0, 1'b0));
        rows.push_back(tick_row(-1000, HEADING_MAX, 1'b0, 0, 0, 1'b0));
        rows.push_back(tick_row(POS_MIN, 0, 1'b0, 0, 0, 1'b0));
        // Initial level already above the cap: ramp never engages.
        rows.push_back(start_row(1000, 46080, 1'b1, (1 << DRIVE_W) - 1, 1));
        rows.push_back(tick_row(0, 46080, 1'b0, 0, 0, 1'b0));
        // One-tick ramp on a negative PD output, then plain PD.
        rows.push_back(start_row(1000, 0, 1'b1, 9000, 1));
        rows.push_back(tick_row(2000, 0, 1'b0, 0, 0, 1'b0));
        rows.push_back(tick_row(2000, 0, 1'b0, 0, 0, 1'b0));
        // Zero PD output while ramping: drive is zero, flag still set.
        rows.push_back(start_row(0, 0, 1'b1, 5000, 3));
        rows.push_back(tick_row(0, 0, 1'b1, 0, 0, 1'b1));
        rows.push_back(tick_row(0, 0, 1'b0, 0, 0, 1'b0));
        // Ramp disabled, with a level above the cap.
        rows.push_back(start_row(4096, 1, 1'b0, (1 << DRIVE_W) - 1, (1 << TICKS_W) - 1));
        rows.push_back(tick_row(4096, HEADING_MAX, 1'b0, 0, 0, 1'b0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            issue(rows[i].cmd, rows[i].typed, rows[i].want);

        // Random part: each phase writes a fresh gain set while the block is idle.
        for (int phase = 0; phase < GAIN_PHASES; phase++) begin
            s_valid <= 1'b0;
            wait_drained();
            load_gains(phase);
            phase_end = starts_sent + ticks_sent + ITEMS_PER_PHASE;
            while (starts_sent + ticks_sent < phase_end) begin
                if ($urandom_range(0, 99) < 15) begin
                    // Noise: any op, any field value, including stray ticks and back-to-back starts.
                    c = CMD_BITS'({$urandom, $urandom, $urandom, $urandom});
                    issue(c, 1'b0, none);
                end else begin
                    // Well-formed move: a start, then ticks that close in on the target.
                    c.op         = OP_START;
                    c.meas_pos   = POSITION_BITS'($urandom);
                    c.meas_hdg   = HEAD_W'($urandom);
                    c.goal_dist  = ($urandom_range(0, 4) == 0) ? POSITION_BITS'($urandom)
                                                                : pick_position(0);
                    c.goal_hdg   = pick_heading(longint'($urandom_range(0, HEADING_MAX)));
                    c.slew_on    = ($urandom_range(0, 4) != 0);
                    case ($urandom_range(0, 2))
                        0: c.slew_init = DRIVE_W'($urandom_range(0, drive_cap));
                        1: c.slew_init = DRIVE_W'($urandom);
                        default: begin
                            off = longint'($urandom_range(0, 200));
                            c.slew_init = DRIVE_W'((drive_cap > off) ? drive_cap - off : 0);
                        end
                    endcase
                    case ($urandom_range(0, 7))
                        0, 1:    c.slew_ticks = '0;
                        2, 3, 4: c.slew_ticks = TICKS_W'($urandom_range(1, 16));
                        5, 6:    c.slew_ticks = TICKS_W'($urandom_range(17, 200));
                        default: c.slew_ticks = TICKS_W'($urandom);
                    endcase
                    issue(c, 1'b0, none);

                    seq_goal = $signed(c.goal_dist);
                    hdg_goal = longint'(c.goal_hdg);
                    hdg_from = longint'($urandom_range(0, HEADING_MAX));
                    n_ticks  = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 24);
                    for (int k = 1; k <= n_ticks; k++) begin
                        c.op         = OP_TICK;
                        c.meas_pos   = pick_position(seq_goal * k / n_ticks);
                        c.meas_hdg   = pick_heading(hdg_from + (hdg_goal - hdg_from) * k / n_ticks);
                        // Start-only fields are don't-care on a tick: randomize them.
                        c.goal_dist  = POSITION_BITS'($urandom);
                        c.goal_hdg   = HEAD_W'($urandom);
                        c.slew_on    = 1'($urandom);
                        c.slew_init  = DRIVE_W'($urandom);
                        c.slew_ticks = TICKS_W'($urandom);
                        issue(c, 1'b0, none);
                    end
                end
            end
        end

        s_valid <= 1'b0;
        wait_drained();

        $display("Covered %0d move starts and %0d ticks over %0d gain settings.",
                 starts_sent, ticks_sent, GAIN_PHASES + 1);
        $display("Checked %0d drive results, %0d from the slew ramp, in %0d cycles.",
                 results_seen, slew_results, cycle_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: switch between open, random, periodic and sparse acceptance.
    initial begin
        rx_mode_t mode;
        int       span;
        int       period;
        m_ready <= 1'b0;
        forever begin
            mode   = rx_mode_t'($urandom_range(0, 3));
            span   = $urandom_range(20, 300);
            period = $urandom_range(2, 40);
            for (int step = 0; step < span; step++) begin
                @(posedge aclk);
                case (mode)
                    RX_OPEN:     m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= 1'($urandom);
                    RX_PERIODIC: m_ready <= ((step % 4) != 3);
                    default:     m_ready <= ((step % period) == 0);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge aclk) begin : result_check
        drive_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drive.size() == 0) begin
                $error("unexpected result: left_drive %0d right_drive %0d slewing %0d",
                       m_left_drive, m_right_drive, m_slewing);
                fail_count++;
            end else begin
                want = expected_drive.pop_front();
                results_seen++;
                if (m_slewing === 1'b1)
                    slew_results++;
                if (m_left_drive !== want.left) begin
                    $error("left_drive mismatch: expected %0d, got %0d",
                           $signed(want.left), m_left_drive);
                    fail_count++;
                end
                if (m_right_drive !== want.right) begin
                    $error("right_drive mismatch: expected %0d, got %0d",
                           $signed(want.right), m_right_drive);
                    fail_count++;
                end
                if (m_slewing !== want.slewing) begin
                    $error("slewing mismatch: expected %0d, got %0d", want.slewing, m_slewing);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
